// ----- hw/rtl/skt_pkg.sv -----
package skt_pkg;

  localparam int TABLE_DEPTH_DEFAULT = 16;

  localparam int MODE_W = 2;
  localparam int KEY_W  = 16;
  localparam int HND_W  = 8;
  localparam int POS_W  = 4;
  localparam int STAT_W = 2;
  localparam int CNT_W  = 5;

  localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
  localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_BAD_POS   = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [HND_W-1:0] handle;
  } entry_t;

endpackage

// ----- hw/rtl/sorted_key_table.sv -----
// channel   signals                                         handshake
// ops in    mode, entry_key, record_handle, position        start && !busy
// result    status, found_position, found_handle,           done, one cycle,
//           entry_count                                     no stall
//
// insert: entries above the new key move up one slot each cycle, then the new
//   entry is written; remove: entries above the position move down one slot
//   each cycle; search: reads upward from slot 0 and stops at the first match,
//   or after the last entry when absent; rejected operations are answered
//   from idle without a scan
// every step is bounded by the single read and single write port of the table ram
// synchronous reset empties the table at once; stored entries are not cleared
module sorted_key_table #(
  parameter int TABLE_DEPTH = skt_pkg::TABLE_DEPTH_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic [skt_pkg::MODE_W-1:0]  mode,
  input  logic [skt_pkg::KEY_W-1:0]   entry_key,
  input  logic [skt_pkg::HND_W-1:0]   record_handle,
  input  logic [skt_pkg::POS_W-1:0]   position,
  output logic                        done,
  output logic [skt_pkg::STAT_W-1:0]  status,
  output logic [skt_pkg::POS_W-1:0]   found_position,
  output logic [skt_pkg::HND_W-1:0]   found_handle,
  output logic [skt_pkg::CNT_W-1:0]   entry_count
);

  import skt_pkg::*;

  localparam int AW   = $clog2(TABLE_DEPTH);
  localparam int CW   = $clog2(TABLE_DEPTH + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PLACE
  } state_t;

  state_t               state;
  logic [MODE_W-1:0]    op;
  logic [KEY_W-1:0]     key_r;
  logic [HND_W-1:0]     hnd_r;
  logic [AW-1:0]        pos_r;
  logic [AW-1:0]        rd_idx;
  logic [AW-1:0]        slot;
  logic [CW-1:0]        count;

  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  entry_t               ram_wdata;
  logic [AW-1:0]        ram_raddr;
  entry_t               rd_data;

  logic                 accept;
  logic                 is_full;
  logic                 pos_bad;
  logic                 at_last;
  logic                 at_pos;
  logic [AW-1:0]        top_idx;

  assign accept  = start && (state == S_IDLE);
  assign busy    = (state != S_IDLE);
  assign is_full = (count == CW'(TABLE_DEPTH));
  assign pos_bad = (CMPW'(position) >= CMPW'(count));
  assign top_idx = AW'(count - CW'(1));
  assign at_last = (rd_idx == top_idx);
  assign at_pos  = (rd_idx == pos_r);

  skt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  // during a scan the read address runs two entries ahead of the write address, so read and write never hit one entry
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = slot;
    ram_wdata = rd_data;
    ram_raddr = rd_idx;
    unique case (state)
      S_IDLE: begin
        if (mode == MODE_INSERT) begin
          ram_raddr = top_idx;
        end else if (mode == MODE_REMOVE) begin
          ram_raddr = AW'(position);
        end else begin
          ram_raddr = '0;
        end
      end
      S_SCAN: begin
        if (op == MODE_INSERT) begin
          ram_raddr = rd_idx - AW'(1);
          if (rd_data.key > key_r) begin
            ram_we    = 1'b1;
            ram_waddr = rd_idx + AW'(1);
          end
        end else if (op == MODE_REMOVE) begin
          ram_raddr = rd_idx + AW'(1);
          if (!at_pos) begin
            ram_we    = 1'b1;
            ram_waddr = rd_idx - AW'(1);
          end
        end else begin
          ram_raddr = rd_idx + AW'(1);
        end
      end
      S_PLACE: begin
        ram_we           = 1'b1;
        ram_waddr        = slot;
        ram_wdata.key    = key_r;
        ram_wdata.handle = hnd_r;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op    <= mode;
            key_r <= entry_key;
            hnd_r <= record_handle;
            pos_r <= AW'(position);
            if (mode == MODE_INSERT) begin
              if (is_full) begin
                done           <= 1'b1;
                status         <= ST_FULL;
                found_position <= '0;
                found_handle   <= '0;
                entry_count    <= CNT_W'(count);
              end else if (count == '0) begin
                slot  <= '0;
                state <= S_PLACE;
              end else begin
                rd_idx <= top_idx;
                state  <= S_SCAN;
              end
            end else if (mode == MODE_REMOVE && !pos_bad) begin
              rd_idx <= AW'(position);
              state  <= S_SCAN;
            end else if (mode == MODE_SEARCH && count != '0) begin
              rd_idx <= '0;
              state  <= S_SCAN;
            end else begin
              done           <= 1'b1;
              status         <= (mode == MODE_SEARCH) ? ST_NOT_FOUND : ST_BAD_POS;
              found_position <= '0;
              found_handle   <= '0;
              entry_count    <= CNT_W'(count);
            end
          end
        end
        S_SCAN: begin
          if (op == MODE_INSERT) begin
            if (rd_data.key > key_r) begin
              if (rd_idx == '0) begin
                slot  <= '0;
                state <= S_PLACE;
              end else begin
                rd_idx <= rd_idx - AW'(1);
              end
            end else begin
              slot  <= rd_idx + AW'(1);
              state <= S_PLACE;
            end
          end else if (op == MODE_REMOVE) begin
            if (at_pos) begin
              hnd_r <= rd_data.handle;
            end
            if (at_last) begin
              done           <= 1'b1;
              status         <= ST_OK;
              found_position <= POS_W'(pos_r);
              found_handle   <= at_pos ? rd_data.handle : hnd_r;
              entry_count    <= CNT_W'(count - CW'(1));
              count          <= count - CW'(1);
              state          <= S_IDLE;
            end else begin
              rd_idx <= rd_idx + AW'(1);
            end
          end else begin
            if (rd_data.key == key_r) begin
              done           <= 1'b1;
              status         <= ST_OK;
              found_position <= POS_W'(rd_idx);
              found_handle   <= rd_data.handle;
              entry_count    <= CNT_W'(count);
              state          <= S_IDLE;
            end else if (at_last) begin
              done           <= 1'b1;
              status         <= ST_NOT_FOUND;
              found_position <= '0;
              found_handle   <= '0;
              entry_count    <= CNT_W'(count);
              state          <= S_IDLE;
            end else begin
              rd_idx <= rd_idx + AW'(1);
            end
          end
        end
        S_PLACE: begin
          done           <= 1'b1;
          status         <= ST_OK;
          found_position <= POS_W'(slot);
          found_handle   <= hnd_r;
          entry_count    <= CNT_W'(count + CW'(1));
          count          <= count + CW'(1);
          state          <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy || done)
    else $error("accepted word neither in progress nor answered");

  a_full_report: assert property (@(posedge clk) disable iff (rst)
    done && status == ST_FULL |-> count == CW'(TABLE_DEPTH))
    else $error("full reported with room left");

  a_place_room: assert property (@(posedge clk) disable iff (rst)
    state == S_PLACE |-> count < CW'(TABLE_DEPTH) && CW'(slot) <= count)
    else $error("placing entry outside the table");

  a_remove_window: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN && op == MODE_REMOVE |-> rd_idx >= pos_r && CW'(rd_idx) < count)
    else $error("remove scan outside its window");
`endif

endmodule

// ----- hw/rtl/skt_ram.sv -----
module skt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
